// ===== rtl/ods_pkg.sv =====
package ods_pkg;

	// Default sizes of the block.
	localparam int STAGES_DEF       = 3;
	localparam int SAMPLE_WIDTH_DEF = 24;

	// Smoothing weight k, unsigned Q0.16.
	localparam int              WEIGHT_W     = 16;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'h8000;

	// Half of one least significant bit after the Q0.16 product is scaled back.
	localparam int ROUND_HALF = 1 << (WEIGHT_W - 1);

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FEED,
		ST_PREP,
		ST_DIFF,
		ST_MUL,
		ST_ADD,
		ST_OUT_A,
		ST_OUT_B,
		ST_POP
	} seq_state_t;

	// Strobes from the sequencer to the shared multiply-add unit.
	typedef struct packed {
		logic load_x;
		logic sel_mid;
		logic load_dif;
		logic load_prod;
	} arith_ctl_t;

endpackage

// ===== rtl/oversampled_difference_smoother_unit.sv =====
// Oversampled difference smoother. Each input item carries a signed sample and a
// block start flag; the block forms the difference to the previous sample and sends
// it through STAGES doubling stages, each of which emits its held input and the
// midpoint to the new one, every emitted value passing a one-pole smoother with
// weight k (Q0.16, written on cfg_wdata, reset one half). Once all stages are warm,
// an item yields 2^STAGES result items, the final one marked by tlast; the first
// item of a block and warm-up items yield fewer or none. Block start clears all
// stage state before the sample is taken. Values go through the stages depth
// first under a small sequencer, and every smoothed value passes the operand,
// difference, product and accumulate steps of the one shared multiply-add unit;
// with three warm stages an item gives fourteen smoothed values. An item occupies
// the block until all its values are done, longer if the result channel stalls.
// The input side is not ready during that time; a finished result waits in the
// output register.
module oversampled_difference_smoother_unit
	import ods_pkg::*;
#(
	parameter int STAGES       = STAGES_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// Bits from the lowest: sample_in, then zero fill.
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	// Bits from the lowest: block_start.
	input  logic                                  s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// Bits from the lowest: sample_out, then zero fill.
	output logic [((SAMPLE_WIDTH+8)/8)*8-1:0]     m_axis_tdata,
	output logic                                  m_axis_tlast,
	input  logic                                  cfg_we,
	input  logic [WEIGHT_W-1:0]                   cfg_wdata
);

	localparam int DW     = SAMPLE_WIDTH + 1;
	localparam int OUT_TW = ((SAMPLE_WIDTH + 8) / 8) * 8;
	localparam int LW     = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam logic [LW-1:0] LAST_LVL = LW'(STAGES - 1);

	seq_state_t state_q, state_d;

	logic [WEIGHT_W-1:0]            weight_q;
	logic signed [SAMPLE_WIDTH-1:0] prev_q;
	logic                           prev_valid_q;
	logic signed [DW-1:0]           pin_q  [STAGES];
	logic signed [DW-1:0]           pout_q [STAGES];
	logic signed [DW-1:0]           pend_q [STAGES];
	logic [STAGES-1:0]              pin_valid_q;
	logic [STAGES-1:0]              pout_valid_q;
	logic [STAGES-1:0]              pend_valid_q;
	logic [LW-1:0]                  lvl_q;
	logic                           half_q;
	logic signed [DW-1:0]           val_q;
	logic signed [DW-1:0]           a_q;
	logic                           out_valid_q;
	logic signed [DW-1:0]           out_data_q;
	logic                           out_last_q;

	logic                           in_acc;
	logic signed [SAMPLE_WIDTH-1:0] x_in;
	logic signed [DW-1:0]           diff;
	logic                           warm;
	logic                           out_free;
	logic                           cur_pin_valid;
	logic                           is_last;
	logic                           any_pend;
	logic [LW-1:0]                  pop_lvl;
	logic                           out_load;
	arith_ctl_t                     ctl;
	logic signed [DW-1:0]           y;

	// Handshake and first difference.
	always_comb begin
		in_acc        = s_axis_tvalid & s_axis_tready;
		x_in          = s_axis_tdata[SAMPLE_WIDTH-1:0];
		diff          = {x_in[SAMPLE_WIDTH-1], x_in} - {prev_q[SAMPLE_WIDTH-1], prev_q};
		warm          = prev_valid_q & ~s_axis_tuser;
		out_free      = ~out_valid_q | m_axis_tready;
		cur_pin_valid = pin_valid_q[lvl_q];
		is_last       = (lvl_q == LAST_LVL);
		any_pend      = |pend_valid_q;
	end

	// The deepest pending value is the next one to resume.
	always_comb begin
		pop_lvl = '0;
		for (int s = 0; s < STAGES; s++) begin
			if (pend_valid_q[s]) begin
				pop_lvl = LW'(s);
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && warm) begin
					state_d = ST_FEED;
				end
			end
			ST_FEED:  state_d = cur_pin_valid ? ST_PREP : ST_POP;
			ST_PREP:  state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_ADD;
			ST_ADD: begin
				if (!half_q) begin
					state_d = ST_PREP;
				end else if (is_last) begin
					state_d = ST_OUT_A;
				end else begin
					state_d = ST_FEED;
				end
			end
			ST_OUT_A: begin
				if (out_free) begin
					state_d = ST_OUT_B;
				end
			end
			ST_OUT_B: begin
				if (out_free) begin
					state_d = ST_POP;
				end
			end
			ST_POP:   state_d = any_pend ? ST_FEED : ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		ctl.load_x    = (state_q == ST_PREP);
		ctl.sel_mid   = half_q;
		ctl.load_dif  = (state_q == ST_DIFF);
		ctl.load_prod = (state_q == ST_MUL);
		out_load      = ((state_q == ST_OUT_A) || (state_q == ST_OUT_B)) && out_free;
	end

	// Shared multiply-add unit.
	ods_arith #(
		.DW(DW)
	) u_arith (
		.clk     (clk),
		.ctl     (ctl),
		.p       (pin_q[lvl_q]),
		.v       (val_q),
		.yp      (pout_q[lvl_q]),
		.yp_valid(pout_valid_q[lvl_q]),
		.k       (weight_q),
		.y       (y)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			weight_q     <= WEIGHT_RESET;
			prev_valid_q <= 1'b0;
			pin_valid_q  <= '0;
			pout_valid_q <= '0;
			pend_valid_q <= '0;
			lvl_q        <= '0;
			half_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				weight_q <= cfg_wdata;
			end
			if (in_acc) begin
				prev_valid_q <= 1'b1;
				lvl_q        <= '0;
				if (s_axis_tuser) begin
					pin_valid_q  <= '0;
					pout_valid_q <= '0;
				end
			end
			if (state_q == ST_FEED) begin
				half_q <= 1'b0;
				if (!cur_pin_valid) begin
					pin_valid_q[lvl_q] <= 1'b1;
				end
			end
			if (state_q == ST_ADD) begin
				half_q              <= ~half_q;
				pout_valid_q[lvl_q] <= 1'b1;
				if (half_q && !is_last) begin
					pend_valid_q[lvl_q] <= 1'b1;
					lvl_q               <= lvl_q + LW'(1);
				end
			end
			if ((state_q == ST_POP) && any_pend) begin
				pend_valid_q[pop_lvl] <= 1'b0;
				lvl_q                 <= pop_lvl + LW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Sample and stage values.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			prev_q <= x_in;
			val_q  <= diff;
		end
		if ((state_q == ST_FEED) && !cur_pin_valid) begin
			pin_q[lvl_q] <= val_q;
		end
		if (state_q == ST_ADD) begin
			pout_q[lvl_q] <= y;
			if (!half_q) begin
				a_q <= y;
			end else begin
				pin_q[lvl_q] <= val_q;
				if (is_last) begin
					val_q <= y;
				end else begin
					pend_q[lvl_q] <= y;
					val_q         <= a_q;
				end
			end
		end
		if ((state_q == ST_POP) && any_pend) begin
			val_q <= pend_q[pop_lvl];
		end
		if (out_load) begin
			out_data_q <= (state_q == ST_OUT_A) ? a_q : val_q;
			out_last_q <= (state_q == ST_OUT_B) && !any_pend;
		end
	end

	// Result channel.
	always_comb begin
		m_axis_tvalid = out_valid_q;
		m_axis_tdata  = OUT_TW'($unsigned(out_data_q));
		m_axis_tlast  = out_last_q;
	end

endmodule

// ===== rtl/ods_arith.sv =====
// Shared arithmetic unit: operand selection (held value or midpoint), difference,
// weight multiply and rounded accumulate of the one-pole smoother.
module ods_arith
	import ods_pkg::*;
#(
	parameter int DW = SAMPLE_WIDTH_DEF + 1
) (
	input  logic                       clk,
	input  arith_ctl_t                 ctl,
	input  logic signed [DW-1:0]       p,
	input  logic signed [DW-1:0]       v,
	input  logic signed [DW-1:0]       yp,
	input  logic                       yp_valid,
	input  logic        [WEIGHT_W-1:0] k,
	output logic signed [DW-1:0]       y
);

	localparam int PW = DW + WEIGHT_W + 1;

	logic signed [DW:0]           mid_sum;
	logic signed [DW-1:0]         x_sel;
	logic signed [DW-1:0]         xs_q;
	logic signed [DW:0]           dif_q;
	logic signed [PW-1:0]         prod_q;
	logic signed [PW-1:0]         prod_rnd;
	logic signed [PW-WEIGHT_W-1:0] corr;
	logic signed [DW:0]           y_wide;

	// Operand: the held input itself, or the midpoint rounded towards minus infinity.
	always_comb begin
		mid_sum = {p[DW-1], p} + {v[DW-1], v};
		x_sel   = ctl.sel_mid ? mid_sum[DW:1] : p;
	end

	// One step of the smoother per strobe: operand, difference, product.
	always_ff @(posedge clk) begin
		if (ctl.load_x) begin
			xs_q <= x_sel;
		end
		if (ctl.load_dif) begin
			dif_q <= {yp[DW-1], yp} - {xs_q[DW-1], xs_q};
		end
		if (ctl.load_prod) begin
			prod_q <= PW'($signed({1'b0, k})) * PW'(dif_q);
		end
	end

	// y = x + round(k * (y_prev - x)); the first value passes unsmoothed.
	always_comb begin
		prod_rnd = prod_q + PW'(ROUND_HALF);
		corr     = prod_rnd[PW-1:WEIGHT_W];
		y_wide   = {xs_q[DW-1], xs_q} + corr;
		y        = yp_valid ? y_wide[DW-1:0] : xs_q;
	end

endmodule
